[design/mhdged_pkg.sv]
// package for the mhd grid energy and divergence block
// holds sizes, register indexes, payload structs and the address helper
// no dependencies
package mhdged_pkg;

   localparam int MAX_SIDE = 16;
   localparam int DEPTH    = MAX_SIDE * MAX_SIDE * MAX_SIDE;
   localparam int SIDE_W   = $clog2(MAX_SIDE + 1);
   localparam int IDX_W    = $clog2(MAX_SIDE);
   localparam int ADDR_W   = $clog2(DEPTH);
   localparam int CNT_W    = ADDR_W + 1;

   localparam int FIELD_W  = 24;
   localparam int SUM_W    = 63;
   localparam int DIV_W    = 25;
   localparam int CSR_W    = 5;
   localparam int CSR_IDX_W = 2;

   localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

   localparam logic [CSR_IDX_W-1:0] CSR_SIZE_X = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SIZE_Y = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SIZE_Z = 2'd2;

   localparam logic [CSR_W-1:0] SIZE_RESET = CSR_W'(MAX_SIDE);

   typedef struct packed {
      logic        [FIELD_W-1:0] density;
      logic        [FIELD_W-1:0] pressure;
      logic signed [FIELD_W-1:0] vel_x;
      logic signed [FIELD_W-1:0] vel_y;
      logic signed [FIELD_W-1:0] vel_z;
      logic signed [FIELD_W-1:0] mag_x;
      logic signed [FIELD_W-1:0] mag_y;
      logic signed [FIELD_W-1:0] mag_z;
      logic                      last_cell;
   } req_data_type;

   typedef struct packed {
      logic [SUM_W-1:0] kinetic_energy;
      logic [SUM_W-1:0] magnetic_energy;
      logic [SUM_W-1:0] thermal_energy;
      logic [DIV_W-1:0] max_divergence;
   } rsp_data_type;

   typedef struct packed {
      logic             busy;
      logic [SUM_W-1:0] kinetic;
      logic [SUM_W-1:0] magnetic;
      logic [SUM_W-1:0] thermal;
   } energy_stat_type;

   // clamp a size register to 1..MAX_SIDE
   function automatic logic [SIDE_W-1:0] clamp_side(input logic [CSR_W-1:0] r);
      logic [SIDE_W-1:0] s;
      if (r == '0) s = SIDE_W'(1);
      else if (r > CSR_W'(MAX_SIDE)) s = SIDE_W'(MAX_SIDE);
      else s = SIDE_W'(r);
      return s;
   endfunction

   function automatic logic [ADDR_W-1:0] addr_of(input logic [IDX_W-1:0] a,
                                                 input logic [IDX_W-1:0] b,
                                                 input logic [IDX_W-1:0] c,
                                                 input logic [SIDE_W-1:0] ny,
                                                 input logic [SIDE_W-1:0] nz);
      logic [2*ADDR_W-1:0] t;
      t = (2*ADDR_W)'(a) * (2*ADDR_W)'(ny) + (2*ADDR_W)'(b);
      t = t * (2*ADDR_W)'(nz) + (2*ADDR_W)'(c);
      return t[ADDR_W-1:0];
   endfunction

   function automatic logic [FIELD_W-1:0] mag24(input logic signed [FIELD_W-1:0] v);
      return v[FIELD_W-1] ? (~v + FIELD_W'(1)) : v;
   endfunction

endpackage

[design/mhd_grid_energy_divergence.sv]
// mhd grid energy and divergence: while idle, one cell per cycle is taken and stored; the
// last cell starts a walk over all nx*ny*nz cells of the field store, one cell per cycle
// (two read ports per component memory), then a drain state waits for the walk and energy
// pipelines to empty before the result item shows; the energy pipeline is 4 deep.
// synchronous reset clears control, accumulators and sizes (to 16); the field store
// is not cleared and needs no clearing pass
module mhd_grid_energy_divergence import mhdged_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  req_data_type         req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output rsp_data_type         rsp_data,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_wdata
);

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_WALK  = 4'b0010,
      ST_DRAIN = 4'b0100,
      ST_EMIT  = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   logic [CSR_W-1:0]  size_x_ff, size_y_ff, size_z_ff;
   logic [SIDE_W-1:0] nx, ny, nz;
   logic [CNT_W-1:0]  count_ff;
   logic [IDX_W-1:0]  i_ff, j_ff, k_ff, i_in, j_in, k_in;
   logic [IDX_W-1:0]  im, ip, jm, jp, km, kp;
   logic              rv1_ff, rv2_ff, rv1_in;
   logic [DIV_W-1:0]  div_ff, max_ff;
   logic              rsp_valid_ff;
   rsp_data_type      rsp_ff;
   logic              accept, emit, last_walk;
   energy_stat_type   estat;

   logic [FIELD_W-1:0] mem_x [DEPTH];
   logic [FIELD_W-1:0] mem_y [DEPTH];
   logic [FIELD_W-1:0] mem_z [DEPTH];
   logic [FIELD_W-1:0] xp_ff, xm_ff, yp_ff, ym_ff, zp_ff, zm_ff;
   logic [ADDR_W-1:0]  a_xp, a_xm, a_yp, a_ym, a_zp, a_zm;

   logic signed [26:0] s_sum;
   logic        [26:0] s_abs;
   logic        [26:0] s_half;

   assign nx = clamp_side(size_x_ff);
   assign ny = clamp_side(size_y_ff);
   assign nz = clamp_side(size_z_ff);

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid & req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         size_x_ff <= SIZE_RESET;
         size_y_ff <= SIZE_RESET;
         size_z_ff <= SIZE_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_SIZE_X: size_x_ff <= csr_wdata;
            CSR_SIZE_Y: size_y_ff <= csr_wdata;
            CSR_SIZE_Z: size_z_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   mhdged_energy u_energy (
      .clock   (clock),
      .reset   (reset),
      .in_valid(accept),
      .in_data (req_data),
      .clear   (emit),
      .stat    (estat)
   );

   // neighbor indexes with periodic wrap
   always_comb begin
      im = (i_ff == '0) ? IDX_W'(nx - SIDE_W'(1)) : i_ff - IDX_W'(1);
      ip = ({1'b0, i_ff} == nx - SIDE_W'(1)) ? '0 : i_ff + IDX_W'(1);
      jm = (j_ff == '0) ? IDX_W'(ny - SIDE_W'(1)) : j_ff - IDX_W'(1);
      jp = ({1'b0, j_ff} == ny - SIDE_W'(1)) ? '0 : j_ff + IDX_W'(1);
      km = (k_ff == '0) ? IDX_W'(nz - SIDE_W'(1)) : k_ff - IDX_W'(1);
      kp = ({1'b0, k_ff} == nz - SIDE_W'(1)) ? '0 : k_ff + IDX_W'(1);
      a_xp = addr_of(ip, j_ff, k_ff, ny, nz);
      a_xm = addr_of(im, j_ff, k_ff, ny, nz);
      a_yp = addr_of(i_ff, jp, k_ff, ny, nz);
      a_ym = addr_of(i_ff, jm, k_ff, ny, nz);
      a_zp = addr_of(i_ff, j_ff, kp, ny, nz);
      a_zm = addr_of(i_ff, j_ff, km, ny, nz);
   end

   // store write on accept, walk reads at two ports per component
   always_ff @(posedge clock) begin
      if (accept && count_ff < CNT_W'(DEPTH)) begin
         mem_x[count_ff[ADDR_W-1:0]] <= req_data.mag_x;
         mem_y[count_ff[ADDR_W-1:0]] <= req_data.mag_y;
         mem_z[count_ff[ADDR_W-1:0]] <= req_data.mag_z;
      end
      xp_ff <= mem_x[a_xp];
      xm_ff <= mem_x[a_xm];
      yp_ff <= mem_y[a_yp];
      ym_ff <= mem_y[a_ym];
      zp_ff <= mem_z[a_zp];
      zm_ff <= mem_z[a_zm];
   end

   always_comb begin
      s_sum = (27'(signed'(xp_ff)) - 27'(signed'(xm_ff)))
            + (27'(signed'(yp_ff)) - 27'(signed'(ym_ff)))
            + (27'(signed'(zp_ff)) - 27'(signed'(zm_ff)));
      s_abs  = s_sum[26] ? 27'(-s_sum) : 27'(s_sum);
      s_half = (s_abs + 27'd1) >> 1;
   end

   assign last_walk = ({1'b0, i_ff} == nx - SIDE_W'(1))
                    && ({1'b0, j_ff} == ny - SIDE_W'(1))
                    && ({1'b0, k_ff} == nz - SIDE_W'(1));
   assign emit = (state_ff == ST_EMIT) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      state_in = state_ff;
      i_in     = i_ff;
      j_in     = j_ff;
      k_in     = k_ff;
      rv1_in   = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            i_in = '0;
            j_in = '0;
            k_in = '0;
            if (accept && req_data.last_cell) state_in = ST_WALK;
         end
         ST_WALK: begin
            rv1_in = 1'b1;
            if (last_walk) begin
               state_in = ST_DRAIN;
            end else if ({1'b0, k_ff} == nz - SIDE_W'(1)) begin
               k_in = '0;
               if ({1'b0, j_ff} == ny - SIDE_W'(1)) begin
                  j_in = '0;
                  i_in = i_ff + IDX_W'(1);
               end else begin
                  j_in = j_ff + IDX_W'(1);
               end
            end else begin
               k_in = k_ff + IDX_W'(1);
            end
         end
         ST_DRAIN: begin
            if (!rv1_ff && !rv2_ff && !estat.busy) state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (emit) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         i_ff         <= '0;
         j_ff         <= '0;
         k_ff         <= '0;
         rv1_ff       <= 1'b0;
         rv2_ff       <= 1'b0;
         max_ff       <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         i_ff     <= i_in;
         j_ff     <= j_in;
         k_ff     <= k_in;
         rv1_ff   <= rv1_in;
         rv2_ff   <= rv1_ff;
         if (emit) begin
            max_ff <= '0;
         end else if (rv2_ff && div_ff > max_ff) begin
            max_ff <= div_ff;
         end
         if (emit) begin
            count_ff <= '0;
         end else if (accept && count_ff < CNT_W'(DEPTH)) begin
            count_ff <= count_ff + CNT_W'(1);
         end
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      div_ff <= s_half[DIV_W-1:0];
      if (emit) begin
         rsp_ff.kinetic_energy  <= estat.kinetic;
         rsp_ff.magnetic_energy <= estat.magnetic;
         rsp_ff.thermal_energy  <= estat.thermal;
         rsp_ff.max_divergence  <= max_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

[design/mhdged_energy.sv]
// energy pipeline: squares, partial products and saturating accumulators
// depends on mhdged_pkg
module mhdged_energy import mhdged_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            in_valid,
   input  req_data_type    in_data,
   input  logic            clear,
   output energy_stat_type stat
);

   localparam int SQ_W = 2 * FIELD_W;
   localparam int KE_W = 39;

   logic              s1_ff, s2_ff, s3_ff;
   logic [SQ_W-1:0]   vx2_ff, vy2_ff, vz2_ff, bx2_ff, by2_ff, bz2_ff;
   logic [FIELD_W-1:0] rho1_ff, p1_ff, rho2_ff;
   logic [SQ_W-1:0]   v2_ff;
   logic [30:0]       b2s2_ff, b2s3_ff;
   logic [25:0]       p3s2_ff, p3s3_ff;
   logic [SQ_W-1:0]   plo_ff, phi_ff;
   logic [SUM_W-1:0]  ke_ff, me_ff, te_ff;
   logic [SUM_W-1:0]  ke_in, me_in, te_in;
   logic [SQ_W-1:0]   b2;
   logic [SQ_W+FIELD_W-1:0] full;
   logic [KE_W-1:0]   ke_add;

   function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] acc,
                                                input logic [SUM_W-1:0] add);
      logic [SUM_W:0] s;
      s = {1'b0, acc} + {1'b0, add};
      return (s > {1'b0, SUM_MAX}) ? SUM_MAX : s[SUM_W-1:0];
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff <= 1'b0;
         s2_ff <= 1'b0;
         s3_ff <= 1'b0;
      end else begin
         s1_ff <= in_valid;
         s2_ff <= s1_ff;
         s3_ff <= s2_ff;
      end
   end

   always_ff @(posedge clock) begin
      vx2_ff  <= SQ_W'(mag24(in_data.vel_x)) * SQ_W'(mag24(in_data.vel_x));
      vy2_ff  <= SQ_W'(mag24(in_data.vel_y)) * SQ_W'(mag24(in_data.vel_y));
      vz2_ff  <= SQ_W'(mag24(in_data.vel_z)) * SQ_W'(mag24(in_data.vel_z));
      bx2_ff  <= SQ_W'(mag24(in_data.mag_x)) * SQ_W'(mag24(in_data.mag_x));
      by2_ff  <= SQ_W'(mag24(in_data.mag_y)) * SQ_W'(mag24(in_data.mag_y));
      bz2_ff  <= SQ_W'(mag24(in_data.mag_z)) * SQ_W'(mag24(in_data.mag_z));
      rho1_ff <= in_data.density;
      p1_ff   <= in_data.pressure;
      v2_ff   <= vx2_ff + vy2_ff + vz2_ff;
      b2s2_ff <= b2[SQ_W-1:17];
      p3s2_ff <= 26'(({2'b00, p1_ff} + {1'b0, p1_ff, 1'b0}) >> 1);
      rho2_ff <= rho1_ff;
      plo_ff  <= SQ_W'(rho2_ff) * SQ_W'(v2_ff[FIELD_W-1:0]);
      phi_ff  <= SQ_W'(rho2_ff) * SQ_W'(v2_ff[SQ_W-1:FIELD_W]);
      b2s3_ff <= b2s2_ff;
      p3s3_ff <= p3s2_ff;
   end

   assign b2 = bx2_ff + by2_ff + bz2_ff;

   // rho * v2 rebuilt from the two partial products, then scaled by 2^-33
   always_comb begin
      full   = {phi_ff, {FIELD_W{1'b0}}} + (SQ_W+FIELD_W)'(plo_ff);
      ke_add = full[33 +: KE_W];
      ke_in  = ke_ff;
      me_in  = me_ff;
      te_in  = te_ff;
      if (clear) begin
         ke_in = '0;
         me_in = '0;
         te_in = '0;
      end else if (s3_ff) begin
         ke_in = sat_add(ke_ff, SUM_W'(ke_add));
         me_in = sat_add(me_ff, SUM_W'(b2s3_ff));
         te_in = sat_add(te_ff, SUM_W'(p3s3_ff));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ke_ff <= '0;
         me_ff <= '0;
         te_ff <= '0;
      end else begin
         ke_ff <= ke_in;
         me_ff <= me_in;
         te_ff <= te_in;
      end
   end

   assign stat.busy     = s1_ff | s2_ff | s3_ff;
   assign stat.kinetic  = ke_ff;
   assign stat.magnetic = me_ff;
   assign stat.thermal  = te_ff;

endmodule

[design/mhdged_checker.sv]
// port-level checks for the mhd grid energy and divergence block, with its bind
// depends on mhdged_pkg and the top level mhd_grid_energy_divergence
module mhdged_checker import mhdged_pkg::*; (
   input logic         clock,
   input logic         reset,
   input logic         req_valid,
   input logic         req_ready,
   input req_data_type req_data,
   input logic         rsp_valid,
   input logic         rsp_ready,
   input rsp_data_type rsp_data
);

   // a stalled result item holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result item changed while stalled");

   // the walk keeps the input closed right after the last cell
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_data.last_cell |=> !req_ready)
      else $error("item taken during the walk");

   // the walk always takes time before a result appears
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_data.last_cell |=> !$rose(rsp_valid))
      else $error("result item with no walk");

   // a result only follows a closed input
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("result item while input open");

endmodule

bind mhd_grid_energy_divergence mhdged_checker u_checker (
   .clock    (clock),
   .reset    (reset),
   .req_valid(req_valid),
   .req_ready(req_ready),
   .req_data (req_data),
   .rsp_valid(rsp_valid),
   .rsp_ready(rsp_ready),
   .rsp_data (rsp_data)
);
